// ----- rtl/ex2q_pkg.sv -----
// ============================================================================
// ex2q_pkg
// Shared constants for the Euler-XYZ to quaternion converter: CORDIC step
// count, gain-corrected start value, internal word widths and arctan table.
// ============================================================================
`default_nettype none

package ex2q_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int XY_WIDTH     = 32;   // Q30 sine and cosine
    localparam int Z_WIDTH      = 34;   // residual angle, full circle = 2^33

    localparam logic signed [XY_WIDTH-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // atan(2^-i), full circle = 2^32.
    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    typedef logic signed [XY_WIDTH-1:0] xy_t;
    typedef logic signed [Z_WIDTH-1:0]  zres_t;

endpackage

`default_nettype wire

// ----- rtl/ex2q_cordic.sv -----
// ============================================================================
// ex2q_cordic
// Fully pipelined rotation-mode CORDIC, one step per register stage. Takes a
// binary angle, halves it and returns the Q30 sine and cosine of the half.
// ============================================================================
`default_nettype none

module ex2q_cordic #(
    parameter int ANGLE_WIDTH = 16
) (
    input  wire                          aclk,
    input  wire                          en,
    input  wire signed [ANGLE_WIDTH-1:0] angle,
    output ex2q_pkg::xy_t                sin_q30,
    output ex2q_pkg::xy_t                cos_q30
);
    import ex2q_pkg::*;

    localparam int ZSHIFT = 32 - ANGLE_WIDTH;

    xy_t   x_reg [CORDIC_STEPS];
    xy_t   y_reg [CORDIC_STEPS];
    zres_t z_reg [CORDIC_STEPS];

    zres_t z_in;
    assign z_in = Z_WIDTH'(angle) <<< ZSHIFT;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        xy_t   x_prev;
        xy_t   y_prev;
        zres_t z_prev;
        xy_t   x_next;
        xy_t   y_next;
        zres_t z_next;
        zres_t rot;

        if (i == 0) begin : g_first
            assign x_prev = CORDIC_GAIN_Q30;
            assign y_prev = '0;
            assign z_prev = z_in;
        end else begin : g_rest
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
        end

        // Each table entry is doubled because the residual runs at twice the scale.
        assign rot = zres_t'({ATAN_TAB[i], 1'b0});

        always_comb begin
            if (!z_prev[Z_WIDTH-1]) begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - rot;
            end else begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + rot;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign sin_q30 = y_reg[CORDIC_STEPS-1];
    assign cos_q30 = x_reg[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/euler_xyz_to_quaternion.sv -----
// ============================================================================
// euler_xyz_to_quaternion
// Converts three Euler-XYZ binary angles to a saturated fixed-point unit
// quaternion through three CORDIC pipelines and a three-stage product tree.
// ============================================================================
//
//  channel | dir | tdata fields (low bit first)
//  --------+-----+-------------------------------------------
//  s_      | in  | angle_x, angle_y, angle_z
//  m_      | out | quat_x, quat_y, quat_z, quat_w
//
// One item enters per cycle while the output is not held; the pipeline has 30
// CORDIC steps, one pair product stage, one triple product stage and one round/saturate stage.
// The whole pipeline advances together; when the output item is held by
// m_tready low, every stage holds and s_tready drops, so nothing is lost.
// Reset clears the valid bits only.
`default_nettype none

module euler_xyz_to_quaternion #(
    parameter int ANGLE_WIDTH = 16,
    parameter int QUAT_WIDTH  = 16
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    // angle_x, angle_y, angle_z, zero padding
    input  wire  [((3*ANGLE_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    // quat_x, quat_y, quat_z, quat_w, zero padding
    output logic [((4*QUAT_WIDTH+7)/8)*8-1:0]       m_tdata
);
    import ex2q_pkg::*;

    localparam int OUT_BITS = ((4*QUAT_WIDTH+7)/8)*8;
    localparam int LATENCY  = CORDIC_STEPS + 3;
    localparam int SUM_W    = 67;
    localparam int SHIFT    = 61 - QUAT_WIDTH;

    localparam logic signed [SUM_W-1:0] RND  = SUM_W'(1) <<< (SHIFT - 1);
    localparam logic signed [SUM_W-1:0] QHI  = (SUM_W'(1) <<< (QUAT_WIDTH-1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] QLO  = -(SUM_W'(1) <<< (QUAT_WIDTH-1));

    logic en;
    logic [LATENCY-1:0] vld_reg;

    assign en       = !vld_reg[LATENCY-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LATENCY-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_tvalid};
        end
    end

    xy_t sx, cx, sy, cy, sz, cz;

    ex2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cx (
        .aclk(aclk), .en(en),
        .angle(s_tdata[ANGLE_WIDTH-1:0]),
        .sin_q30(sx), .cos_q30(cx)
    );
    ex2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cy (
        .aclk(aclk), .en(en),
        .angle(s_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
        .sin_q30(sy), .cos_q30(cy)
    );
    ex2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cz (
        .aclk(aclk), .en(en),
        .angle(s_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]),
        .sin_q30(sz), .cos_q30(cz)
    );

    // Stage 1: the four distinct X/Y pair products, rounded back to Q30.
    logic signed [63:0] pa, pb, pc, pd;
    logic signed [63:0] ra, rb, rc, rd;
    logic signed [32:0] a_reg, b_reg, c_reg, d_reg;
    xy_t sz1_reg, cz1_reg;

    assign pa = 64'(sx) * 64'(cy);
    assign pb = 64'(cx) * 64'(sy);
    assign pc = 64'(sx) * 64'(sy);
    assign pd = 64'(cx) * 64'(cy);
    assign ra = (pa + 64'sd536870912) >>> 30;
    assign rb = (pb + 64'sd536870912) >>> 30;
    assign rc = (pc + 64'sd536870912) >>> 30;
    assign rd = (pd + 64'sd536870912) >>> 30;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= ra[32:0];
            b_reg   <= rb[32:0];
            c_reg   <= rc[32:0];
            d_reg   <= rd[32:0];
            sz1_reg <= sz;
            cz1_reg <= cz;
        end
    end

    // Stage 2: multiply each pair by the Z sine or cosine (Q60).
    logic signed [64:0] acz_reg, asz_reg, bcz_reg, bsz_reg;
    logic signed [64:0] ccz_reg, csz_reg, dcz_reg, dsz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            acz_reg <= 65'(a_reg) * 65'(cz1_reg);
            asz_reg <= 65'(a_reg) * 65'(sz1_reg);
            bcz_reg <= 65'(b_reg) * 65'(cz1_reg);
            bsz_reg <= 65'(b_reg) * 65'(sz1_reg);
            ccz_reg <= 65'(c_reg) * 65'(cz1_reg);
            csz_reg <= 65'(c_reg) * 65'(sz1_reg);
            dcz_reg <= 65'(d_reg) * 65'(cz1_reg);
            dsz_reg <= 65'(d_reg) * 65'(sz1_reg);
        end
    end

    // Stage 3: combine, round to the output scale and saturate.
    function automatic logic [QUAT_WIDTH-1:0] to_q(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] v;
        v = (s + RND) >>> SHIFT;
        if (v > QHI) begin
            v = QHI;
        end else if (v < QLO) begin
            v = QLO;
        end
        return v[QUAT_WIDTH-1:0];
    endfunction

    logic [QUAT_WIDTH-1:0] qx, qy, qz, qw;

    assign qx = to_q(SUM_W'(acz_reg) + SUM_W'(bsz_reg));
    assign qy = to_q(SUM_W'(bcz_reg) - SUM_W'(asz_reg));
    assign qz = to_q(SUM_W'(ccz_reg) + SUM_W'(dsz_reg));
    assign qw = to_q(SUM_W'(dcz_reg) - SUM_W'(csz_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= OUT_BITS'({qw, qz, qy, qx});
        end
    end

endmodule

`default_nettype wire

// ----- tb/quat_checker.sv -----
// ----------------------------------------------------------------------------
// quat_checker
// Watches both channels of the Euler-XYZ to quaternion converter, computes
// the expected quaternion of every accepted angle item and compares results.
// ----------------------------------------------------------------------------
module quat_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [47:0] s_tdata,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [63:0] m_tdata,
    output int         err_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ex2q_pkg::*;

    logic [63:0] quat_q[$];

    assign pending = quat_q.size();

    // Runs the 30-step CORDIC on the half angle and returns Q30 sine and cosine.
    function automatic void half_sincos(input logic signed [15:0] ang,
                                        output longint sn, output longint cs);
        longint zr, xr, yr, dx, dy;
        zr = longint'(ang) <<< 16;
        xr = CORDIC_GAIN_Q30;
        yr = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0) begin
                xr -= dx; yr += dy; zr -= 2 * longint'(ATAN_TAB[i]);
            end else begin
                xr += dx; yr -= dy; zr += 2 * longint'(ATAN_TAB[i]);
            end
        end
        sn = yr;
        cs = xr;
    endfunction

    function automatic longint triple(longint a, longint b, longint c);
        return ((a * b + (64'sd1 <<< 29)) >>> 30) * c;
    endfunction

    function automatic logic [15:0] to_q15(longint q60);
        longint v;
        v = (q60 + (64'sd1 <<< 44)) >>> 45;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [63:0] predict_quat(logic [47:0] d);
        longint sx, cx, sy, cy, sz, cz;
        half_sincos(d[15:0], sx, cx);
        half_sincos(d[31:16], sy, cy);
        half_sincos(d[47:32], sz, cz);
        return {to_q15(triple(cx, cy, cz) - triple(sx, sy, sz)),
                to_q15(triple(sx, sy, cz) + triple(cx, cy, sz)),
                to_q15(triple(cx, sy, cz) - triple(sx, cy, sz)),
                to_q15(triple(sx, cy, cz) + triple(cx, sy, sz))};
    endfunction

    always @(posedge aclk) begin
        logic [63:0] want;
        if (!aresetn) begin
            err_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                quat_q.push_back(predict_quat(s_tdata));
            if (m_tvalid && m_tready) begin
                if (quat_q.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    err_count++;
                end else begin
                    want = quat_q.pop_front();
                    if (want[15:0] != m_tdata[15:0]) begin
                        $error("quat_x exp %h got %h", want[15:0], m_tdata[15:0]);
                        err_count++;
                    end
                    if (want[31:16] != m_tdata[31:16]) begin
                        $error("quat_y exp %h got %h", want[31:16], m_tdata[31:16]);
                        err_count++;
                    end
                    if (want[47:32] != m_tdata[47:32]) begin
                        $error("quat_z exp %h got %h", want[47:32], m_tdata[47:32]);
                        err_count++;
                    end
                    if (want[63:48] != m_tdata[63:48]) begin
                        $error("quat_w exp %h got %h", want[63:48], m_tdata[63:48]);
                        err_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random Euler angle items into the converter under
// changing source and sink idling; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          err_count;
    int          pending;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    euler_xyz_to_quaternion u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    quat_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .err_count(err_count), .pending(pending)
    );

    always @(posedge aclk) begin
        if (aresetn)
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Presents one item, with an optional random gap first, and waits for it.
    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(($urandom_range(3)) << 14) + 16'($urandom_range(3)) - 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] dir_vals[8];
        dir_vals = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000,
                     16'hC000, 16'h0001, 16'hFFFF, 16'h2000};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed part: zeros, minus pi, near plus pi, quarter turns, +/-1 LSB, an eighth turn, mixes.
        for (int i = 0; i < 8; i++)
            send_angles(dir_vals[i], dir_vals[i], dir_vals[i]);
        for (int i = 0; i < 8; i++)
            send_angles(dir_vals[i], dir_vals[(i + 3) % 8], dir_vals[(i + 5) % 8]);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
        send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 74 : 0;
            snk_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 13 : 0;
            for (int n = 0; n < 183; n++) begin
                send_angles(pick_angle(), pick_angle(), pick_angle());
                if (n == 90) begin
                    // Let the pipeline drain completely before going on.
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Sent %0d angle items: extremes, quarter turns and random angles,", items_sent);
        $display("under three source/sink idling mixes including a full drain.");
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/ex2q_pkg.sv
rtl/ex2q_cordic.sv
rtl/euler_xyz_to_quaternion.sv
tb/quat_checker.sv
tb/testbench.sv
